@@ rtl/core/cidf_pkg.sv @@
// ----------------------------------------------------------------------------
// cidf_pkg
// Shared types, constants and helpers for the CAN ID acceptance filter table.
// ----------------------------------------------------------------------------
`default_nettype none

package cidf_pkg;

    localparam int DEPTH_DEF = 512;
    localparam int ID_W      = 11;
    localparam int WORD_W    = 32;
    localparam int RIDX_W    = 9;
    localparam int STAT_W    = 3;
    localparam int HALF_W    = 16;
    localparam int DIS_BIT   = 12;
    localparam int CHN_W     = 3;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    typedef logic [STAT_W-1:0] status_t;

    localparam status_t STAT_ADDED   = 3'd0;
    localparam status_t STAT_ENABLED = 3'd1;
    localparam status_t STAT_FULL    = 3'd2;
    localparam status_t STAT_EXT     = 3'd3;
    localparam status_t STAT_READ    = 3'd4;

    typedef logic [ID_W-1:0]   frame_id_t;
    typedef logic [WORD_W-1:0] word_t;

    // one half: chnum[15:13], disable[12], zero[11], id[10:0]
    function automatic logic [HALF_W-1:0] make_half(input frame_id_t id,
                                                    input logic [CHN_W-1:0] chnum,
                                                    input logic dis);
        make_half = {chnum, dis, 1'b0, id};
    endfunction

    // new word: only the requesting channel enabled
    function automatic word_t make_word(input frame_id_t id, input logic ch);
        make_word = {make_half(id, CHN_W'(1), ~ch), make_half(id, CHN_W'(0), ch)};
    endfunction

    function automatic word_t dis_mask(input logic ch);
        word_t m;
        m = '0;
        m[DIS_BIT + (ch ? HALF_W : 0)] = 1'b1;
        dis_mask = m;
    endfunction

    function automatic frame_id_t half_id(input word_t w, input logic ch);
        half_id = ch ? w[HALF_W +: ID_W] : w[ID_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/cidf_in_if.sv @@
// ----------------------------------------------------------------------------
// cidf_in_if
// Request channel: insert/enable an ID, or read one filter word.
// ----------------------------------------------------------------------------
`default_nettype none

interface cidf_in_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic                         channel;
    logic [cidf_pkg::ID_W-1:0]    frame_id;
    logic                         extended;
    logic [cidf_pkg::RIDX_W-1:0]  read_index;

    modport source (output valid, func, channel, frame_id, extended, read_index,
                    input ready);
    modport sink   (input valid, func, channel, frame_id, extended, read_index,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/cidf_out_if.sv @@
// ----------------------------------------------------------------------------
// cidf_out_if
// Response channel: one word per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface cidf_out_if;
    logic                         valid;
    logic                         ready;
    logic [cidf_pkg::STAT_W-1:0]  status;
    logic [cidf_pkg::RIDX_W-1:0]  position;
    logic [cidf_pkg::WORD_W-1:0]  word_data;

    modport source (output valid, status, position, word_data, input ready);
    modport sink   (input valid, status, position, word_data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cidf_ram.sv @@
// ----------------------------------------------------------------------------
// cidf_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cidf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/can_id_filter_sorted_insert_top.sv @@
// ----------------------------------------------------------------------------
// can_id_filter_sorted_insert_top
// Sorted table of 11-bit standard CAN IDs for a two-channel acceptance filter.
// ----------------------------------------------------------------------------
// The table sits in one DEPTH x 32 RAM, kept in ascending ID order, and one
// request is worked at a time. A read whose index is at or beyond the fill
// count skips the RAM. An insert scans the table one word per cycle from
// index 0 (one RAM read a cycle) until it meets the ID, a larger one or the
// end of the table, then, for a new ID, moves every word from the insert
// point p to the end up by one, one word per cycle through the same RAM, and
// writes the new word. The scan reads words 0 to p and the move reads words
// p to the end, so between them they cover the n used words.
// Words beyond the fill count read as zero, so no clearing pass runs after
// reset. A finished result waits in an output register; the next request is
// taken as soon as the previous result has moved there.
`default_nettype none

module can_id_filter_sorted_insert_top #(
    parameter int DEPTH = cidf_pkg::DEPTH_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    cidf_in_if.sink    req,
    cidf_out_if.source rsp
);

    import cidf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_WRNEW  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [AW-1:0]     src_reg, src_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic              chan_reg, chan_next;
    frame_id_t         id_reg, id_next;
    status_t           res_status_reg, res_status_next;
    logic [RIDX_W-1:0] res_pos_reg, res_pos_next;
    word_t             res_data_reg, res_data_next;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [RIDX_W-1:0] out_pos_reg, out_pos_next;
    word_t             out_data_reg, out_data_next;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    word_t             ram_wdata, ram_rdata;

    logic [CW-1:0]     idx_inc;
    logic [CW-1:0]     count_m1;
    frame_id_t         cur_id;
    logic              rd_ok;

    cidf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.position  = out_pos_reg;
    assign rsp.word_data = out_data_reg;

    assign idx_inc  = idx_reg + CW'(1);
    assign count_m1 = count_reg - CW'(1);
    assign cur_id   = half_id(ram_rdata, chan_reg);
    assign rd_ok    = 32'(req.read_index) < 32'(count_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        src_next        = src_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        chan_next       = chan_reg;
        id_next         = id_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_data_next   = res_data_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = pend_addr_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    chan_next = req.channel;
                    id_next   = req.frame_id;
                    idx_next  = '0;
                    if (req.func == FUNC_READ)
                    begin
                        res_status_next = STAT_READ;
                        res_pos_next    = req.read_index;
                        res_data_next   = '0;
                        if (rd_ok)
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = AW'(req.read_index);
                            state_next = S_RDWAIT;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                    else if (req.extended)
                    begin
                        res_status_next = STAT_EXT;
                        res_pos_next    = '0;
                        res_data_next   = '0;
                        state_next      = S_FINISH;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                // read of the next word goes out while this one is compared
                ram_re    = 1'b1;
                ram_raddr = idx_inc[AW-1:0];
                if (id_reg < cur_id)
                begin
                    state_next = S_DECIDE;
                end
                else if (id_reg == cur_id)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = idx_reg[AW-1:0];
                    ram_wdata       = ram_rdata & ~dis_mask(chan_reg);
                    res_status_next = STAT_ENABLED;
                    res_pos_next    = RIDX_W'(idx_reg);
                    res_data_next   = ram_rdata & ~dis_mask(chan_reg);
                    state_next      = S_FINISH;
                end
                else
                begin
                    idx_next = idx_inc;
                    if (idx_inc == count_reg)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_DECIDE:
            begin
                if (count_reg == CW'(DEPTH))
                begin
                    res_status_next = STAT_FULL;
                    res_pos_next    = RIDX_W'(idx_reg);
                    res_data_next   = '0;
                    state_next      = S_FINISH;
                end
                else
                begin
                    rem_next   = count_reg - idx_reg;
                    src_next   = count_m1[AW-1:0];
                    pend_next  = 1'b0;
                    state_next = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                // read word k-1 now, write it to k next cycle
                if (pend_reg)
                begin
                    ram_we = 1'b1;
                end
                if (rem_reg != '0)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = src_reg;
                    pend_next      = 1'b1;
                    pend_addr_next = src_reg + AW'(1);
                    src_next       = src_reg - AW'(1);
                    rem_next       = rem_reg - CW'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_WRNEW;
                end
            end

            S_WRNEW:
            begin
                ram_we          = 1'b1;
                ram_waddr       = idx_reg[AW-1:0];
                ram_wdata       = make_word(id_reg, chan_reg);
                count_next      = count_reg + CW'(1);
                res_status_next = STAT_ADDED;
                res_pos_next    = RIDX_W'(idx_reg);
                res_data_next   = make_word(id_reg, chan_reg);
                state_next      = S_FINISH;
            end

            S_RDWAIT:
            begin
                res_data_next = ram_rdata;
                state_next    = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pos_next    = res_pos_reg;
                    out_data_next   = res_data_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        rem_reg        <= rem_next;
        src_reg        <= src_next;
        pend_addr_reg  <= pend_addr_next;
        chan_reg       <= chan_next;
        id_reg         <= id_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_data_reg   <= res_data_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_data_reg   <= out_data_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/cidf_checker.sv @@
// ----------------------------------------------------------------------------
// cidf_checker
// Port-level assertions for the CAN ID filter table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cidf_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           rsp_valid,
    input wire logic                           rsp_ready,
    input wire logic [cidf_pkg::STAT_W-1:0]    rsp_status,
    input wire logic [cidf_pkg::RIDX_W-1:0]    rsp_position,
    input wire logic [cidf_pkg::WORD_W-1:0]    rsp_word_data
);

    import cidf_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response word dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_word_data) && $stable(rsp_status))
        else $error("response word changed while stalled");

    a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == STAT_FULL || rsp_status == STAT_EXT)
        |-> rsp_word_data == '0)
        else $error("full or extended response carries data");

    a_halves_match: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == STAT_ADDED || rsp_status == STAT_ENABLED)
        |-> rsp_word_data[ID_W-1:0] == rsp_word_data[HALF_W +: ID_W])
        else $error("inserted word halves hold different IDs");

    a_ext_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == STAT_EXT |-> rsp_position == '0)
        else $error("extended response with nonzero position");

endmodule

bind can_id_filter_sorted_insert_top cidf_checker u_cidf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_position  (rsp.position),
    .rsp_word_data (rsp.word_data)
);

`default_nettype wire

@@ verif/can_id_filter_sorted_insert_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_id_filter_sorted_insert_top_tb
// Checks the sorted CAN ID filter table: inserts, enables, reads, full table.
// ----------------------------------------------------------------------------
// Requests are sent one word at a time. On acceptance, each request goes
// through a local copy of the table, which yields the response word that
// should come back. A checker compares every response word, field by field,
// with the oldest outstanding one. The run covers an empty table, sorted
// inserts, enables of existing IDs, ignored extended requests, and reads.
// It then fills the table to capacity and exercises the full-table
// behavior. Sender gaps and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
`default_nettype none

module can_id_filter_sorted_insert_top_tb;

    import cidf_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int CLK_HALF_NS    = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int ID_MAX         = (1 << ID_W) - 1;
    localparam int RIDX_MAX       = (1 << RIDX_W) - 1;

    typedef struct packed {
        logic              func;
        logic              channel;
        frame_id_t         frame_id;
        logic              extended;
        logic [RIDX_W-1:0] read_index;
    } filter_req_t;

    typedef struct packed {
        status_t           status;
        logic [RIDX_W-1:0] position;
        word_t             word_data;
    } filter_result_t;

    logic clk;
    logic rst_n;

    cidf_in_if  req_if ();
    cidf_out_if rsp_if ();

    can_id_filter_sorted_insert_top #(
        .DEPTH (DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    word_t          table_words [DEPTH];
    int             std_count;
    int             used_count;
    filter_result_t expected_q [$];
    int             fail_count;
    int             send_idle_pct;
    int             rsp_stall_pct;
    int             quiet_cycles;

    always #(CLK_HALF_NS) clk = ~clk;

    // ------------------------------------------------------------------
    // Table predictor
    // ------------------------------------------------------------------
    function automatic frame_id_t stored_id(input word_t w, input logic ch);
        stored_id = ch ? w[HALF_W +: ID_W] : w[ID_W-1:0];
    endfunction

    function automatic bit id_present(input frame_id_t id);
        id_present = 1'b0;
        for (int k = 0; k < used_count; k++)
        begin
            if (stored_id(table_words[k], 1'b0) == id)
                id_present = 1'b1;
        end
    endfunction

    function automatic filter_result_t predict_filter(input filter_req_t r);
        filter_result_t res;
        int             idx;
        int             scan_end;
        int             k;
        bit             hit;
        res = '{status: STAT_READ, position: '0, word_data: '0};
        if (r.func == FUNC_READ)
        begin
            res.position  = r.read_index;
            res.word_data = table_words[r.read_index];
        end
        else if (r.extended)
        begin
            res.status = STAT_EXT;
        end
        else
        begin
            scan_end = (std_count < DEPTH) ? std_count : DEPTH;
            idx = 0;
            while (idx < scan_end && r.frame_id > stored_id(table_words[idx], r.channel))
                idx++;
            hit = (idx < scan_end) && (stored_id(table_words[idx], r.channel) == r.frame_id);
            res.position = RIDX_W'(idx);
            if (hit)
            begin
                table_words[idx][DIS_BIT + (r.channel ? HALF_W : 0)] = 1'b0;
                res.status    = STAT_ENABLED;
                res.word_data = table_words[idx];
            end
            else if (used_count >= DEPTH)
            begin
                res.status = STAT_FULL;
            end
            else
            begin
                for (k = used_count; k > idx; k--)
                    table_words[k] = table_words[k-1];
                // high half: channel number 1, low half: channel number 0
                res.word_data = {3'd1, ~r.channel, 1'b0, r.frame_id,
                                 3'd0,  r.channel, 1'b0, r.frame_id};
                table_words[idx] = res.word_data;
                std_count++;
                used_count++;
                res.status = STAT_ADDED;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request builders: ignored fields get random values
    // ------------------------------------------------------------------
    function automatic filter_req_t insert_req(input logic ch, input frame_id_t id,
                                               input logic ext);
        insert_req = '{func: FUNC_INSERT, channel: ch, frame_id: id, extended: ext,
                       read_index: RIDX_W'($urandom_range(0, RIDX_MAX))};
    endfunction

    function automatic filter_req_t read_req(input int idx);
        read_req = '{func: FUNC_READ, channel: 1'($urandom_range(0, 1)),
                     frame_id: ID_W'($urandom_range(0, ID_MAX)),
                     extended: 1'($urandom_range(0, 1)), read_index: RIDX_W'(idx)};
    endfunction

    // 2047 is kept out of the table so a full table can see an ID above all
    function automatic frame_id_t pick_absent_id();
        frame_id_t id;
        id = ID_W'($urandom_range(0, ID_MAX - 1));
        while (id_present(id))
            id = ID_W'($urandom_range(0, ID_MAX - 1));
        return id;
    endfunction

    function automatic frame_id_t pick_stored_id();
        pick_stored_id = stored_id(table_words[$urandom_range(0, used_count - 1)], 1'b0);
    endfunction

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    task automatic set_idle(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        rsp_stall_pct = stall_pct;
    endtask

    task automatic issue_request(input filter_req_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.func       <= r.func;
        req_if.channel    <= r.channel;
        req_if.frame_id   <= r.frame_id;
        req_if.extended   <= r.extended;
        req_if.read_index <= r.read_index;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        expected_q.push_back(predict_filter(r));
    endtask

    always @(posedge clk)
    begin
        rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end

    always @(posedge clk)
    begin
        filter_result_t exp_word;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected response word: status %0d position %0d data %08h",
                       rsp_if.status, rsp_if.position, rsp_if.word_data);
                fail_count++;
            end
            else
            begin
                exp_word = expected_q.pop_front();
                if (rsp_if.status !== exp_word.status)
                begin
                    $error("status: expected %0d, got %0d", exp_word.status, rsp_if.status);
                    fail_count++;
                end
                if (rsp_if.position !== exp_word.position)
                begin
                    $error("position: expected %0d, got %0d",
                           exp_word.position, rsp_if.position);
                    fail_count++;
                end
                if (rsp_if.word_data !== exp_word.word_data)
                begin
                    $error("word_data: expected %08h, got %08h",
                           exp_word.word_data, rsp_if.word_data);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("can_id_filter_sorted_insert_top_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_empty_and_ignored;
        issue_request(read_req(0));
        issue_request(read_req(RIDX_MAX));
        issue_request(insert_req(1'b1, ID_W'(ID_MAX), 1'b1));
        issue_request(insert_req(1'b0, ID_W'(0), 1'b1));
    endtask

    task automatic test_sorted_insert;
        issue_request(insert_req(1'b0, ID_W'('h400), 1'b0));
        issue_request(insert_req(1'b1, ID_W'(0), 1'b0));
        issue_request(insert_req(1'b0, ID_W'(ID_MAX - 1), 1'b0));
        issue_request(insert_req(1'b1, ID_W'('h555), 1'b0));
        issue_request(insert_req(1'b0, ID_W'('h2AA), 1'b0));
        issue_request(insert_req(1'b1, ID_W'('h3FF), 1'b0));
    endtask

    task automatic test_enable_existing;
        issue_request(insert_req(1'b1, ID_W'('h400), 1'b0));
        issue_request(insert_req(1'b1, ID_W'('h400), 1'b0));
        issue_request(insert_req(1'b0, ID_W'(0), 1'b0));
        issue_request(insert_req(1'b1, ID_W'('h555), 1'b0));
        issue_request(insert_req(1'b0, ID_W'(ID_MAX - 1), 1'b1));
    endtask

    task automatic test_readback;
        for (int k = 0; k <= 7; k++)
            issue_request(read_req(k));
        issue_request(read_req('h155));
        issue_request(read_req('h0AA));
    endtask

    task automatic test_random_traffic(input int n_words);
        int          pick;
        filter_req_t r;
        repeat (n_words)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                r = insert_req(1'($urandom_range(0, 1)), pick_absent_id(), 1'b0);
            else if (pick < 55 && used_count > 0)
                r = insert_req(1'($urandom_range(0, 1)), pick_stored_id(), 1'b0);
            else if (pick < 68)
                r = read_req($urandom_range(0, used_count));
            else if (pick < 80)
                r = read_req($urandom_range(0, RIDX_MAX));
            else if (pick < 90)
                r = insert_req(1'($urandom_range(0, 1)),
                               ID_W'($urandom_range(0, ID_MAX)), 1'b1);
            else
                r = insert_req(1'($urandom_range(0, 1)),
                               ID_W'($urandom_range(0, ID_MAX - 1)), 1'b0);
            issue_request(r);
        end
    endtask

    task automatic test_fill_to_capacity;
        int added;
        added = 0;
        while (used_count < DEPTH)
        begin
            case ((added / 100) % 4)
                0: set_idle(0, 0);
                1: set_idle(72, 0);
                2: set_idle(0, 72);
                default: set_idle(34, 34);
            endcase
            issue_request(insert_req(1'($urandom_range(0, 1)), pick_absent_id(), 1'b0));
            added++;
        end
    endtask

    task automatic test_full_table;
        filter_req_t r;
        issue_request(read_req(RIDX_MAX));
        issue_request(insert_req(1'b0, ID_W'(ID_MAX), 1'b0));
        issue_request(insert_req(1'b1, ID_W'(ID_MAX), 1'b1));
        repeat (30)
        begin
            case ($urandom_range(0, 4))
                0: r = insert_req(1'($urandom_range(0, 1)), pick_absent_id(), 1'b0);
                1: r = insert_req(1'($urandom_range(0, 1)), pick_stored_id(), 1'b0);
                2: r = read_req($urandom_range(0, RIDX_MAX));
                3: r = insert_req(1'($urandom_range(0, 1)),
                                  ID_W'($urandom_range(0, ID_MAX)), 1'b1);
                default: r = insert_req(1'($urandom_range(0, 1)), ID_W'(ID_MAX), 1'b0);
            endcase
            issue_request(r);
        end
    endtask

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        req_if.valid       = 1'b0;
        req_if.func        = FUNC_INSERT;
        req_if.channel     = 1'b0;
        req_if.frame_id    = '0;
        req_if.extended    = 1'b0;
        req_if.read_index  = '0;
        rsp_if.ready       = 1'b0;
        fail_count         = 0;
        quiet_cycles       = 0;
        std_count          = 0;
        used_count         = 0;
        foreach (table_words[k])
            table_words[k] = '0;
        set_idle(0, 0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_ignored();
        test_sorted_insert();
        test_enable_existing();
        test_readback();

        set_idle(0, 0);
        test_random_traffic(40);
        set_idle(72, 0);
        test_random_traffic(40);
        set_idle(0, 72);
        test_random_traffic(40);
        set_idle(34, 34);
        test_random_traffic(40);

        test_fill_to_capacity();

        set_idle(34, 34);
        test_full_table();

        req_if.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("can_id_filter_sorted_insert_top_tb OK");
        else
            $display("can_id_filter_sorted_insert_top_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/cidf_pkg.sv
rtl/core/cidf_in_if.sv
rtl/core/cidf_out_if.sv
rtl/core/cidf_ram.sv
rtl/core/can_id_filter_sorted_insert_top.sv
rtl/core/cidf_checker.sv
verif/can_id_filter_sorted_insert_top_tb.sv
